/* src/ldd_pkg.sv */
// Package with the types, codes and constants of the LED display driver.
`default_nettype none

package ldd_pkg;

    localparam int REG_COUNT  = 8;
    localparam int REG_IDX_W  = $clog2(REG_COUNT);
    localparam int REG_ADDR_W = 3;
    localparam int REG_DATA_W = 8;
    localparam int PERIOD_W   = 16;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [PERIOD_W-1:0] LONG_PERIOD_RESET = 16'd50;

    // Operation codes of an input word.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Configuration register indexes.
    localparam logic [0:0] CFG_LONG_PERIOD = 1'b0;

    // Mode nibble codes of a display register.
    localparam logic [3:0] NIB_OFF  = 4'h1;
    localparam logic [3:0] NIB_SLOW = 4'h2;
    localparam logic [3:0] NIB_FAST = 4'h3;
    localparam logic [3:0] NIB_FWD  = 4'h4;
    localparam logic [3:0] NIB_BWD  = 4'h5;

    // Snapshot mode flag codes.
    localparam logic [3:0] FLAG_OFF = 4'h0;
    localparam logic [3:0] FLAG_ON  = 4'h1;
    localparam logic [3:0] FLAG_FWD = 4'hE;
    localparam logic [3:0] FLAG_BWD = 4'hF;

    // Slot codes.
    localparam logic [1:0] SLOT_LEFT_BAR   = 2'd0;
    localparam logic [1:0] SLOT_LEFT_DIGIT = 2'd1;
    localparam logic [1:0] SLOT_RIGHT_DIGIT = 2'd2;
    localparam logic [1:0] SLOT_RIGHT_BAR  = 2'd3;

    // Pattern table codes.
    localparam logic [1:0] TBL_BAR   = 2'd0;
    localparam logic [1:0] TBL_DIGIT = 2'd1;
    localparam logic [1:0] TBL_ANIM  = 2'd2;

    localparam logic [REG_IDX_W-1:0] ARROW_REG  = REG_IDX_W'(4);
    localparam logic [REG_IDX_W-1:0] BUZZER_REG = REG_IDX_W'(5);

    localparam logic [2:0] ANIM_LEN = 3'd6;
    localparam logic [1:0] SLOW_DIV = 2'd3;
    localparam logic [3:0] BAR_ANIM_LAST = 4'd5;
    localparam logic [3:0] ANIM_LEN_IDX  = 4'd6;

    typedef struct packed {
        logic                  op;
        logic [REG_ADDR_W-1:0] reg_addr;
        logic [REG_DATA_W-1:0] reg_data;
    } in_word_t;

    typedef struct packed {
        logic [1:0] digit_slot;
        logic [1:0] pattern_table;
        logic [3:0] pattern_index;
        logic       slot_enable;
        logic       arrows_valid;
        logic       arrow_down;
        logic       arrow_up;
        logic       buzzer;
    } out_word_t;

    typedef struct packed {
        logic     valid;
        in_word_t word;
    } step_t;

endpackage

`default_nettype wire

/* src/ldd_in_if.sv */
// Interface of the input channel that carries register writes and ticks.
`default_nettype none

interface ldd_in_if import ldd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [REG_ADDR_W-1:0] reg_addr;
    logic [REG_DATA_W-1:0] reg_data;

    modport source (output valid, op, reg_addr, reg_data, input ready);
    modport sink (input valid, op, reg_addr, reg_data, output ready);
endinterface

`default_nettype wire

/* src/ldd_out_if.sv */
// Interface of the output channel that carries one slot drive word per tick.
`default_nettype none

interface ldd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] digit_slot;
    logic [1:0] pattern_table;
    logic [3:0] pattern_index;
    logic       slot_enable;
    logic       arrows_valid;
    logic       arrow_down;
    logic       arrow_up;
    logic       buzzer;

    modport source (output valid, digit_slot, pattern_table, pattern_index, slot_enable,
                    arrows_valid, arrow_down, arrow_up, buzzer, input ready);
    modport sink (input valid, digit_slot, pattern_table, pattern_index, slot_enable,
                  arrows_valid, arrow_down, arrow_up, buzzer, output ready);
endinterface

`default_nettype wire

/* src/ldd_apb_regs.sv */
// APB configuration register block holding the long tick period.
`default_nettype none

module ldd_apb_regs import ldd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [PERIOD_W-1:0]   long_period
);

    logic [PERIOD_W-1:0] long_period_reg;
    logic                sel_period;
    logic                wr_en;

    assign pready     = 1'b1;
    assign sel_period = (paddr[2:2] == CFG_LONG_PERIOD);
    assign wr_en      = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_period_reg <= LONG_PERIOD_RESET;
        end
        else if (wr_en && sel_period)
        begin
            long_period_reg <= pwdata[PERIOD_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (sel_period)
        begin
            prdata = APB_DATA_W'(long_period_reg);
        end
    end

    assign long_period = long_period_reg;

endmodule

`default_nettype wire

/* src/ldd_engine.sv */
// Display state, blink and animation counters and the slot drive logic.
`default_nettype none

module ldd_engine import ldd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire step_t               step,
    input  wire logic [PERIOD_W-1:0] long_period,
    output out_word_t                result
);

    logic [REG_DATA_W-1:0] display_regs_reg [REG_COUNT];
    logic [3:0]            mode_flags_reg [REG_COUNT];
    logic [3:0]            snap_next [REG_COUNT];
    logic [PERIOD_W-1:0]   tick_count_reg;
    logic [1:0]            slow_div_reg;
    logic                  slow_phase_reg;
    logic                  fast_phase_reg;
    logic [2:0]            anim_step_reg;
    logic [1:0]            slot_reg;

    logic [PERIOD_W-1:0]   tick_inc;
    logic                  long_tick;
    logic [1:0]            slow_div_inc;
    logic                  slow_wrap;
    logic [1:0]            slow_div_next;
    logic                  slow_phase_next;
    logic                  fast_phase_next;
    logic [2:0]            anim_inc;
    logic [2:0]            anim_step_next;
    logic                  write_en;
    logic                  tick_en;
    logic                  is_bar;
    logic [3:0]            mode;
    logic [REG_DATA_W-1:0] disp;
    logic [3:0]            anim_idx;

    function automatic logic [3:0] mode_of(input logic [3:0] nib, input logic slow,
                                           input logic fast);
        logic [3:0] flag;
        unique case (nib)
            NIB_OFF:  flag = FLAG_OFF;
            NIB_SLOW: flag = {3'b000, slow};
            NIB_FAST: flag = {3'b000, fast};
            NIB_FWD:  flag = FLAG_FWD;
            NIB_BWD:  flag = FLAG_BWD;
            default:  flag = FLAG_ON;
        endcase
        return flag;
    endfunction

    assign write_en = step.valid && (step.word.op == OP_WRITE)
                      && (32'(step.word.reg_addr) < REG_COUNT);
    assign tick_en  = step.valid && (step.word.op == OP_TICK);

    assign tick_inc        = tick_count_reg + 16'd1;
    assign long_tick       = (tick_inc >= long_period);
    assign slow_div_inc    = slow_div_reg + 2'd1;
    assign slow_wrap       = (slow_div_inc >= SLOW_DIV);
    assign slow_div_next   = slow_wrap ? 2'd0 : slow_div_inc;
    assign slow_phase_next = slow_phase_reg ^ slow_wrap;
    assign fast_phase_next = ~fast_phase_reg;
    assign anim_inc        = anim_step_reg + 3'd1;
    assign anim_step_next  = (anim_inc >= ANIM_LEN) ? 3'd0 : anim_inc;

    always_comb
    begin
        for (int i = 0; i < REG_COUNT; i++)
        begin
            snap_next[i] = mode_of(display_regs_reg[i][7:4], slow_phase_next,
                                   fast_phase_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                display_regs_reg[i] <= '0;
                mode_flags_reg[i]   <= '0;
            end
            tick_count_reg <= '0;
            slow_div_reg   <= '0;
            slow_phase_reg <= 1'b0;
            fast_phase_reg <= 1'b0;
            anim_step_reg  <= '0;
            slot_reg       <= '0;
        end
        else
        begin
            if (write_en)
            begin
                display_regs_reg[REG_IDX_W'(step.word.reg_addr)] <= step.word.reg_data;
            end
            if (tick_en)
            begin
                slot_reg <= slot_reg + 2'd1;
                if (long_tick)
                begin
                    tick_count_reg <= '0;
                    slow_div_reg   <= slow_div_next;
                    slow_phase_reg <= slow_phase_next;
                    fast_phase_reg <= fast_phase_next;
                    anim_step_reg  <= anim_step_next;
                    for (int i = 0; i < REG_COUNT; i++)
                    begin
                        mode_flags_reg[i] <= snap_next[i];
                    end
                end
                else
                begin
                    tick_count_reg <= tick_inc;
                end
            end
        end
    end

    assign is_bar   = (slot_reg == SLOT_LEFT_BAR) || (slot_reg == SLOT_RIGHT_BAR);
    assign mode     = mode_flags_reg[REG_IDX_W'(slot_reg)];
    assign disp     = display_regs_reg[REG_IDX_W'(slot_reg)];
    assign anim_idx = {1'b0, anim_step_reg};

    always_comb
    begin
        result               = '0;
        result.digit_slot    = slot_reg;
        result.pattern_table = is_bar ? TBL_BAR : TBL_ANIM;
        if (mode == FLAG_FWD)
        begin
            result.pattern_index = anim_idx;
            result.slot_enable   = 1'b1;
        end
        else if (mode == FLAG_BWD)
        begin
            if (is_bar)
            begin
                result.pattern_index = BAR_ANIM_LAST - anim_idx;
            end
            else if (anim_step_reg == 3'd0)
            begin
                result.pattern_index = 4'd0;
            end
            else
            begin
                result.pattern_index = ANIM_LEN_IDX - anim_idx;
            end
            result.slot_enable = 1'b1;
        end
        else if (is_bar)
        begin
            result.pattern_index = {1'b0, disp[2:0]};
            result.slot_enable   = mode[0];
            if (slot_reg == SLOT_LEFT_BAR)
            begin
                result.arrows_valid = 1'b1;
                result.arrow_down   = display_regs_reg[ARROW_REG][0];
                result.arrow_up     = display_regs_reg[ARROW_REG][1];
            end
        end
        else
        begin
            result.pattern_table = TBL_DIGIT;
            result.pattern_index = disp[3:0];
            result.slot_enable   = mode[0];
        end
        result.buzzer = long_tick ? snap_next[BUZZER_REG][0]
                                  : mode_flags_reg[BUZZER_REG][0];
    end

endmodule

`default_nettype wire

/* src/led_mux_blink_display_driver_top.sv */
// Top level of the multiplexed LED display driver with blink and animation modes.
//
// The in_ch channel takes words that are either display register writes or
// multiplex ticks. A write updates one of the eight display registers and
// produces nothing on the output. Each tick produces one word on out_ch that
// tells which of the four slots to drive, which pattern table and entry to
// use, whether the slot is on, the arrow bits and the buzzer drive.
// The long_period register on the APB port sets how many ticks make one long
// tick, which steps the blink and animation counters; write it only while idle.
// A word is registered in the input register and processed by the engine as it
// leaves it; a tick's result is then held in the output register, which drives
// out_ch until the receiver takes it. One word is accepted every cycle
// as long as the output register is free or being emptied in the same cycle;
// a write in the input register never waits on the output.
// When the receiver stalls, the result stays in the output register, a following
// tick waits in the input register and in_ch ready drops.
// Reset clears all display registers, mode flags and counters and sets
// long_period to 50.
`default_nettype none

module led_mux_blink_display_driver_top import ldd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    ldd_in_if.sink                     in_ch,
    ldd_out_if.source                  out_ch,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    logic                s1_valid_reg;
    in_word_t            s1_word_reg;
    logic                out_valid_reg;
    out_word_t           out_word_reg;
    logic                out_free;
    logic                advance;
    logic                in_fire;
    in_word_t            in_word;
    step_t               step;
    out_word_t           result;
    logic [PERIOD_W-1:0] long_period;

    ldd_apb_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .long_period (long_period)
    );

    assign in_word.op       = in_ch.op;
    assign in_word.reg_addr = in_ch.reg_addr;
    assign in_word.reg_data = in_ch.reg_data;

    assign out_free    = !out_valid_reg || out_ch.ready;
    assign advance     = s1_valid_reg && ((s1_word_reg.op == OP_WRITE) || out_free);
    assign in_ch.ready = !s1_valid_reg || advance;
    assign in_fire     = in_ch.valid && in_ch.ready;

    assign step.valid = advance;
    assign step.word  = s1_word_reg;

    ldd_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .long_period (long_period),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_word_reg <= in_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && (s1_word_reg.op == OP_TICK))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && (s1_word_reg.op == OP_TICK))
        begin
            out_word_reg <= result;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.digit_slot    = out_word_reg.digit_slot;
    assign out_ch.pattern_table = out_word_reg.pattern_table;
    assign out_ch.pattern_index = out_word_reg.pattern_index;
    assign out_ch.slot_enable   = out_word_reg.slot_enable;
    assign out_ch.arrows_valid  = out_word_reg.arrows_valid;
    assign out_ch.arrow_down    = out_word_reg.arrow_down;
    assign out_ch.arrow_up      = out_word_reg.arrow_up;
    assign out_ch.buzzer        = out_word_reg.buzzer;

endmodule

`default_nettype wire

/* sim/led_mux_blink_display_driver_top_tb.sv */
// Testbench for the LED display driver: directed and random writes and ticks checked against a predictor.
`timescale 1ns / 1ps

module led_mux_blink_display_driver_top_tb;
    import ldd_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int NUM_PHASES   = 8;
    localparam int MAX_REPORTS  = 10;

    class slot_drive_scoreboard;
        logic [REG_DATA_W-1:0] disp_regs [REG_COUNT];
        logic [3:0]            flags [REG_COUNT];
        logic [PERIOD_W-1:0]   period;
        logic [PERIOD_W-1:0]   tick_cnt;
        logic [1:0]            slow_div;
        logic                  slow_ph;
        logic                  fast_ph;
        logic [2:0]            anim;
        logic [1:0]            slot_cnt;
        out_word_t             drive_q [$];
        int                    mismatches;

        function new();
            for (int i = 0; i < REG_COUNT; i++)
            begin
                disp_regs[i] = '0;
                flags[i] = '0;
            end
            period = LONG_PERIOD_RESET;
            tick_cnt = '0;
            slow_div = '0;
            slow_ph = 1'b0;
            fast_ph = 1'b0;
            anim = '0;
            slot_cnt = '0;
            mismatches = 0;
        endfunction

        function logic [3:0] flag_of(logic [REG_DATA_W-1:0] r);
            case (r[7:4])
                NIB_OFF:  return FLAG_OFF;
                NIB_SLOW: return {3'b000, slow_ph};
                NIB_FAST: return {3'b000, fast_ph};
                NIB_FWD:  return FLAG_FWD;
                NIB_BWD:  return FLAG_BWD;
                default:  return FLAG_ON;
            endcase
        endfunction

        function void long_tick();
            slow_div = slow_div + 2'd1;
            if (slow_div >= SLOW_DIV)
            begin
                slow_div = '0;
                slow_ph = ~slow_ph;
            end
            fast_ph = ~fast_ph;
            anim = anim + 3'd1;
            if (anim >= ANIM_LEN)
                anim = '0;
            for (int i = 0; i < REG_COUNT; i++)
                flags[i] = flag_of(disp_regs[i]);
        endfunction

        function void note_word(in_word_t w);
            out_word_t  d;
            logic [3:0] mode;
            logic       is_bar;
            if (w.op == OP_WRITE)
            begin
                if (int'(w.reg_addr) < REG_COUNT)
                    disp_regs[w.reg_addr] = w.reg_data;
                return;
            end
            d = '0;
            d.digit_slot = slot_cnt;
            is_bar = (slot_cnt == SLOT_LEFT_BAR) || (slot_cnt == SLOT_RIGHT_BAR);
            mode = flags[slot_cnt];
            d.pattern_table = is_bar ? TBL_BAR : TBL_ANIM;
            if (mode == FLAG_FWD)
            begin
                d.pattern_index = {1'b0, anim};
                d.slot_enable = 1'b1;
            end
            else if (mode == FLAG_BWD)
            begin
                if (is_bar)
                    d.pattern_index = 4'(BAR_ANIM_LAST - {1'b0, anim});
                else if (anim == 3'd0)
                    d.pattern_index = 4'd0;
                else
                    d.pattern_index = 4'(ANIM_LEN_IDX - {1'b0, anim});
                d.slot_enable = 1'b1;
            end
            else if (is_bar)
            begin
                d.pattern_index = {1'b0, disp_regs[slot_cnt][2:0]};
                d.slot_enable = mode[0];
                if (slot_cnt == SLOT_LEFT_BAR)
                begin
                    d.arrows_valid = 1'b1;
                    d.arrow_down = disp_regs[ARROW_REG][0];
                    d.arrow_up = disp_regs[ARROW_REG][1];
                end
            end
            else
            begin
                d.pattern_table = TBL_DIGIT;
                d.pattern_index = disp_regs[slot_cnt][3:0];
                d.slot_enable = mode[0];
            end
            slot_cnt = slot_cnt + 2'd1;
            tick_cnt = tick_cnt + 16'd1;
            if (tick_cnt >= period)
            begin
                tick_cnt = '0;
                long_tick();
            end
            d.buzzer = flags[BUZZER_REG][0];
            drive_q.push_back(d);
        endfunction

        function string fmt(out_word_t d);
            return $sformatf("slot %0d tbl %0d idx %0d en %0b av %0b dn %0b up %0b bz %0b",
                             d.digit_slot, d.pattern_table, d.pattern_index, d.slot_enable,
                             d.arrows_valid, d.arrow_down, d.arrow_up, d.buzzer);
        endfunction

        function void check_drive(out_word_t got);
            out_word_t want;
            if (drive_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Unexpected word: %s", fmt(got));
                return;
            end
            want = drive_q.pop_front();
            if (got.digit_slot !== want.digit_slot || got.pattern_table !== want.pattern_table ||
                got.pattern_index !== want.pattern_index || got.slot_enable !== want.slot_enable ||
                got.arrows_valid !== want.arrows_valid || got.arrow_down !== want.arrow_down ||
                got.arrow_up !== want.arrow_up || got.buzzer !== want.buzzer)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Mismatch: expected %s, got %s", fmt(want), fmt(got));
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int send_idle_pct;
    int recv_stall_pct;

    slot_drive_scoreboard sb = new();

    ldd_in_if  in_ch ();
    ldd_out_if out_ch ();

    led_mux_blink_display_driver_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        out_ch.ready = 1'b1;
        forever
        begin
            @(negedge clk);
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        out_word_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                got.digit_slot = out_ch.digit_slot;
                got.pattern_table = out_ch.pattern_table;
                got.pattern_index = out_ch.pattern_index;
                got.slot_enable = out_ch.slot_enable;
                got.arrows_valid = out_ch.arrows_valid;
                got.arrow_down = out_ch.arrow_down;
                got.arrow_up = out_ch.arrow_up;
                got.buzzer = out_ch.buzzer;
                sb.check_drive(got);
            end
        end
    end

    function automatic in_word_t mk(logic op, logic [REG_ADDR_W-1:0] addr,
                                    logic [REG_DATA_W-1:0] data);
        in_word_t w;
        w.op = op;
        w.reg_addr = addr;
        w.reg_data = data;
        return w;
    endfunction

    function automatic in_word_t random_word();
        in_word_t w;
        w.op = ($urandom_range(99) < 55) ? OP_TICK : OP_WRITE;
        w.reg_addr = REG_ADDR_W'($urandom_range(7));
        if ($urandom_range(99) < 85)
            w.reg_data = {4'($urandom_range(5)), 4'($urandom_range(15))};
        else
            w.reg_data = 8'($urandom);
        return w;
    endfunction

    task automatic send_word(in_word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op <= w.op;
        in_ch.reg_addr <= w.reg_addr;
        in_ch.reg_data <= w.reg_data;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.note_word(w);
        @(negedge clk);
    endtask

    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (sb.drive_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (addr == APB_ADDR_W'(4 * int'(CFG_LONG_PERIOD)))
            sb.period = data[PERIOD_W-1:0];
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial
    begin
        in_word_t dir_q [$];
        int ph_period [NUM_PHASES] = '{2, 3, 65535, 3, 0, 7, -1, 50};
        int ph_idle [NUM_PHASES]   = '{0, 78, 0, 21, 0, 78, 0, 21};
        int ph_stall [NUM_PHASES]  = '{0, 0, 78, 21, 0, 0, 78, 21};
        int ph_items [NUM_PHASES]  = '{125, 125, 60, 125, 125, 125, 125, 125};
        int period;
        logic [APB_ADDR_W-1:0] period_addr;

        period_addr = APB_ADDR_W'(4 * int'(CFG_LONG_PERIOD));
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.op = OP_WRITE;
        in_ch.reg_addr = '0;
        in_ch.reg_data = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // With a period of one, every tick is also a long tick.
        apb_write(period_addr, 32'd1);
        dir_q.push_back(mk(OP_WRITE, 3'd0, 8'h07));
        dir_q.push_back(mk(OP_WRITE, 3'd1, 8'h19));
        dir_q.push_back(mk(OP_WRITE, 3'd2, 8'h2F));
        dir_q.push_back(mk(OP_WRITE, 3'd3, 8'h3A));
        dir_q.push_back(mk(OP_WRITE, ARROW_REG, 8'h03));
        dir_q.push_back(mk(OP_WRITE, BUZZER_REG, 8'h01));
        dir_q.push_back(mk(OP_WRITE, 3'd6, 8'hFF));
        dir_q.push_back(mk(OP_WRITE, 3'd7, 8'h00));
        repeat (4) dir_q.push_back(mk(OP_TICK, 3'd7, 8'hFF));
        dir_q.push_back(mk(OP_WRITE, 3'd0, 8'h40));
        dir_q.push_back(mk(OP_WRITE, 3'd1, 8'h4F));
        dir_q.push_back(mk(OP_WRITE, 3'd2, 8'h50));
        dir_q.push_back(mk(OP_WRITE, 3'd3, 8'h5F));
        dir_q.push_back(mk(OP_WRITE, BUZZER_REG, 8'h10));
        repeat (8) dir_q.push_back(mk(OP_TICK, 3'd0, 8'h00));
        dir_q.push_back(mk(OP_WRITE, ARROW_REG, 8'h00));
        dir_q.push_back(mk(OP_WRITE, 3'd0, 8'h6E));
        dir_q.push_back(mk(OP_WRITE, 3'd3, 8'hF7));
        repeat (4) dir_q.push_back(mk(OP_TICK, 3'd5, 8'h5A));
        foreach (dir_q[i])
            send_word(dir_q[i]);
        wait_drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            period = (ph_period[p] < 0) ? int'($urandom_range(12, 1)) : ph_period[p];
            apb_write(period_addr, APB_DATA_W'(period));
            send_idle_pct = ph_idle[p];
            recv_stall_pct = ph_stall[p];
            for (int n = 0; n < ph_items[p]; n++)
            begin
                if (n == 40)
                    wait_drain();
                send_word(random_word());
            end
            wait_drain();
        end

        if (sb.mismatches == 0 && sb.drive_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* led_mux_blink_display_driver_top.f */
src/ldd_pkg.sv
src/ldd_in_if.sv
src/ldd_out_if.sv
src/ldd_apb_regs.sv
src/ldd_engine.sv
src/led_mux_blink_display_driver_top.sv
sim/led_mux_blink_display_driver_top_tb.sv
